[src/srq_pkg.sv]
// Shared types and constants for the sorted ready queue.
`timescale 1ns / 1ps
`default_nettype none

package srq_pkg;

  // Default sizes handed to the top level.
  localparam int QUEUE_DEPTH_DEF = 512;
  localparam int TIME_WIDTH_DEF  = 16;
  localparam int PRIO_WIDTH_DEF  = 8;

  // Width of a task index, fixed by the item format.
  localparam int INDEX_WIDTH = 9;

  // Cells whose search flag ripples through combinationally before a register.
  localparam int SEG_CELLS = 8;

  // Operation codes carried in the input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_IDLE   = 3'd0,
    CELL_APPEND = 3'd1,
    CELL_SCAN   = 3'd2,
    CELL_INSERT = 3'd3,
    CELL_POP    = 3'd4
  } cell_op_t;

endpackage

`default_nettype wire

[src/srq_cell.sv]
// One storage cell of the queue row, holding one entry and its search flag.
`timescale 1ns / 1ps
`default_nettype none

module srq_cell #(
  parameter int QUEUE_DEPTH = 512,
  parameter int TIME_WIDTH  = 16,
  parameter int PRIO_WIDTH  = 8,
  parameter int CELL_ID     = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire srq_pkg::cell_op_t                  op,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
  input  wire logic [srq_pkg::INDEX_WIDTH-1:0]    new_index,
  input  wire logic [TIME_WIDTH-1:0]              new_tkey,
  input  wire logic [PRIO_WIDTH-1:0]              new_prio,
  input  wire logic [srq_pkg::INDEX_WIDTH-1:0]    left_index,
  input  wire logic [TIME_WIDTH-1:0]              left_time,
  input  wire logic [PRIO_WIDTH-1:0]              left_prio,
  input  wire logic [srq_pkg::INDEX_WIDTH-1:0]    right_index,
  input  wire logic [TIME_WIDTH-1:0]              right_time,
  input  wire logic [PRIO_WIDTH-1:0]              right_prio,
  input  wire logic                               seen_in,
  input  wire logic                               left_seen,
  output logic                                    seen_out,
  output logic                                    seen,
  output logic [srq_pkg::INDEX_WIDTH-1:0]         cur_index,
  output logic [TIME_WIDTH-1:0]                   cur_tkey,
  output logic [PRIO_WIDTH-1:0]                   cur_prio
);
  import srq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic in_use;
  logic tail;
  logic beats;
  logic hit;

  // The cell holds a live entry when its place lies below the fill count;
  // the first free place is the tail.
  always_comb begin
    in_use   = CNT_W'(CELL_ID) < count;
    tail     = CNT_W'(CELL_ID) == count;
    beats    = (new_tkey < cur_tkey) ||
               ((new_tkey == cur_tkey) && (new_prio > cur_prio));
    hit      = in_use ? beats : tail;
    seen_out = seen_in | hit;
  end

  // Search flag: set once this cell or one ahead of it takes the new entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else begin
      case (op)
        CELL_SCAN:   seen <= seen_out;
        CELL_INSERT: seen <= 1'b0;
        default:     ;
      endcase
    end
  end

  // Entry payload: load the new item, take the left neighbour or the right.
  always_ff @(posedge clk) begin
    case (op)
      CELL_APPEND: begin
        if (tail) begin
          cur_index <= new_index;
          cur_tkey  <= new_tkey;
          cur_prio  <= new_prio;
        end
      end
      CELL_INSERT: begin
        if (seen && !left_seen) begin
          cur_index <= new_index;
          cur_tkey  <= new_tkey;
          cur_prio  <= new_prio;
        end else if (seen) begin
          cur_index <= left_index;
          cur_tkey  <= left_time;
          cur_prio  <= left_prio;
        end
      end
      CELL_POP: begin
        cur_index <= right_index;
        cur_tkey  <= right_time;
        cur_prio  <= right_prio;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/sorted_ready_queue.sv]
// Top level of the sorted ready queue: control, result register and the cell row.
// A pop, a first-in first-out push or a dropped push gives its result in the cycle
// after acceptance; a sorted push steps through the scan state as the search flag
// ripples through the cell row eight cells per cycle, then through the apply state.
// One item at a time: the next waits until the last is done and its result is taken.
// Reset (rst, synchronous) empties the queue and selects first-in first-out mode.
`timescale 1ns / 1ps
`default_nettype none

module sorted_ready_queue #(
  parameter int QUEUE_DEPTH = srq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_WIDTH  = srq_pkg::TIME_WIDTH_DEF,
  parameter int PRIO_WIDTH  = srq_pkg::PRIO_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  // Fields from bit 0: entry_index, time_key, prio_key, zero padding.
  input  wire logic [((srq_pkg::INDEX_WIDTH+TIME_WIDTH+PRIO_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // Fields from bit 0: op.
  input  wire logic [0:0] s_axis_tuser,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  // Fields from bit 0: popped_index, popped_valid, overflow, occupancy, zero padding.
  output logic [((srq_pkg::INDEX_WIDTH+2+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);
  import srq_pkg::*;

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_SEG = (QUEUE_DEPTH + SEG_CELLS - 1) / SEG_CELLS;
  localparam int SCAN_W  = $clog2(NUM_SEG + 1);
  localparam int OCC_LSB = INDEX_WIDTH + 2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [SCAN_W-1:0]       scan_cnt, scan_cnt_next;
  logic                    sorted_mode;

  logic [INDEX_WIDTH-1:0]  hold_index;
  logic [TIME_WIDTH-1:0]   hold_time;
  logic [PRIO_WIDTH-1:0]   hold_prio;

  logic [INDEX_WIDTH-1:0]  out_index;
  logic                    out_valid;
  logic                    out_ovf;
  logic [CNT_W-1:0]        out_occ;

  logic                    accept;
  logic                    in_op;
  logic [INDEX_WIDTH-1:0]  in_index;
  logic [TIME_WIDTH-1:0]   in_time;
  logic [PRIO_WIDTH-1:0]   in_prio;
  logic                    full;
  logic                    empty;
  logic                    res_load;
  logic [INDEX_WIDTH-1:0]  res_index;
  logic                    res_valid;
  logic                    res_ovf;
  cell_op_t                cell_op;
  logic [INDEX_WIDTH-1:0]  new_index;
  logic [TIME_WIDTH-1:0]   new_tkey;
  logic [PRIO_WIDTH-1:0]   new_prio;

  logic [INDEX_WIDTH-1:0]  cell_index [QUEUE_DEPTH];
  logic [TIME_WIDTH-1:0]   cell_time  [QUEUE_DEPTH];
  logic [PRIO_WIDTH-1:0]   cell_prio  [QUEUE_DEPTH];
  logic                    seen_comb  [QUEUE_DEPTH];
  logic                    seen_reg   [QUEUE_DEPTH];

  // Unpack the input item and the output item.
  always_comb begin
    in_op    = s_axis_tuser[0];
    in_index = s_axis_tdata[INDEX_WIDTH-1:0];
    in_time  = s_axis_tdata[INDEX_WIDTH +: TIME_WIDTH];
    in_prio  = s_axis_tdata[INDEX_WIDTH+TIME_WIDTH +: PRIO_WIDTH];

    m_axis_tdata                          = '0;
    m_axis_tdata[INDEX_WIDTH-1:0]         = out_index;
    m_axis_tdata[INDEX_WIDTH]             = out_valid;
    m_axis_tdata[INDEX_WIDTH+1]           = out_ovf;
    m_axis_tdata[OCC_LSB +: CNT_W]        = out_occ;
  end

  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = count == CNT_W'(QUEUE_DEPTH);
  assign empty         = count == '0;

  // The new entry comes straight from the input when handled at once,
  // otherwise from the holding registers during a sorted search.
  always_comb begin
    new_index = (state == ST_IDLE) ? in_index : hold_index;
    new_tkey  = (state == ST_IDLE) ? in_time  : hold_time;
    new_prio  = (state == ST_IDLE) ? in_prio  : hold_prio;
  end

  // Sequencing of one item and the result it produces.
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    cell_op       = CELL_IDLE;
    res_load      = 1'b0;
    res_index     = '0;
    res_valid     = 1'b0;
    res_ovf       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_POP) begin
            res_load = 1'b1;
            if (!empty) begin
              cell_op    = CELL_POP;
              res_index  = cell_index[0];
              res_valid  = 1'b1;
              count_next = count - CNT_W'(1);
            end
          end else if (full) begin
            res_load = 1'b1;
            res_ovf  = 1'b1;
          end else if (!sorted_mode) begin
            res_load   = 1'b1;
            cell_op    = CELL_APPEND;
            count_next = count + CNT_W'(1);
          end else begin
            scan_cnt_next = '0;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cell_op       = CELL_SCAN;
        scan_cnt_next = scan_cnt + SCAN_W'(1);
        if (scan_cnt == SCAN_W'(NUM_SEG - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cell_op    = CELL_INSERT;
        res_load   = 1'b1;
        count_next = count + CNT_W'(1);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      scan_cnt      <= '0;
      sorted_mode   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      if (cfg_wr_en) begin
        sorted_mode <= cfg_wr_data;
      end
      if (res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Held keys for the sorted search and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_index <= in_index;
      hold_time  <= in_time;
      hold_prio  <= in_prio;
    end
    if (res_load) begin
      out_index <= res_index;
      out_valid <= res_valid;
      out_ovf   <= res_ovf;
      out_occ   <= count_next;
    end
  end

  // Row of cells; the head sits in cell 0.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : gen_cell
    logic [INDEX_WIDTH-1:0] l_index, r_index;
    logic [TIME_WIDTH-1:0]  l_time,  r_time;
    logic [PRIO_WIDTH-1:0]  l_prio,  r_prio;
    logic                   l_seen_in, l_seen;

    if (k == 0) begin : gen_left_edge
      assign l_index   = '0;
      assign l_time    = '0;
      assign l_prio    = '0;
      assign l_seen_in = 1'b0;
      assign l_seen    = 1'b0;
    end else begin : gen_left
      assign l_index = cell_index[k-1];
      assign l_time  = cell_time[k-1];
      assign l_prio  = cell_prio[k-1];
      assign l_seen  = seen_reg[k-1];
      // A register breaks the search ripple at each segment boundary.
      if (k % SEG_CELLS == 0) begin : gen_seg_edge
        assign l_seen_in = seen_reg[k-1];
      end else begin : gen_seg_inner
        assign l_seen_in = seen_comb[k-1];
      end
    end

    if (k == QUEUE_DEPTH - 1) begin : gen_right_edge
      assign r_index = '0;
      assign r_time  = '0;
      assign r_prio  = '0;
    end else begin : gen_right
      assign r_index = cell_index[k+1];
      assign r_time  = cell_time[k+1];
      assign r_prio  = cell_prio[k+1];
    end

    srq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH),
      .PRIO_WIDTH  (PRIO_WIDTH),
      .CELL_ID     (k)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .count       (count),
      .new_index   (new_index),
      .new_tkey    (new_tkey),
      .new_prio    (new_prio),
      .left_index  (l_index),
      .left_time   (l_time),
      .left_prio   (l_prio),
      .right_index (r_index),
      .right_time  (r_time),
      .right_prio  (r_prio),
      .seen_in     (l_seen_in),
      .left_seen   (l_seen),
      .seen_out    (seen_comb[k]),
      .seen        (seen_reg[k]),
      .cur_index   (cell_index[k]),
      .cur_tkey    (cell_time[k]),
      .cur_prio    (cell_prio[k])
    );
  end

endmodule

`default_nettype wire
